>>> sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared request codes, sequencer states and character constants.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [2:0] {
    REQ_PUT    = 3'd0,
    REQ_INPUT  = 3'd1,
    REQ_BS     = 3'd2,
    REQ_FLUSH  = 3'd3,
    REQ_SWITCH = 3'd4,
    REQ_COLOR  = 3'd5,
    REQ_READ   = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_PUT_WR,
    ST_SC_RD,
    ST_SC_WR,
    ST_SC_BLANK,
    ST_INC,
    ST_FL_RD,
    ST_FL_WR,
    ST_FL_ERD,
    ST_FL_ELD,
    ST_FL_NL2,
    ST_FL_CLR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  BLANK_CODE   = 8'h20;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

endpackage
`default_nettype wire

>>> sv/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int DEPTH = 8000,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Multi-terminal text console: cell store in one RAM, echo buffer in another.
// ----------------------------------------------------------------------------
// Usage: each request item on the in_ channel (put char, input char,
// backspace, flush, switch terminal, set colour, read cell) gives exactly one
// result item on the out_ channel with the active terminal's cursor, pending
// input count, index and the cell read. One item is processed at a time.
// A put char that scrolls walks the cell store through the single RAM
// port pair: each moved cell is read and then written, and each cell of
// the last row is blanked. A flush copies the pending input to the echo
// RAM, then writes a newline, each character back as a put char, and a
// second newline, and clears the pending count; with nothing pending it
// writes only a newline.
// After reset a clearing pass writes every cell of every terminal,
// TERMINALS*ROWS*COLUMNS cells (8000 at the defaults); in_ready stays low
// until it ends. A result waits in the output register while out_ready is
// low; the next item is taken only once that result has been loaded.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int TERMINALS = 4,
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_color_value,
  input  wire logic [1:0]  in_terminal_index,
  input  wire logic [10:0] in_cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_cursor_col,
  output logic [4:0]       out_cursor_row,
  output logic [15:0]      out_cell_value,
  output logic [1:0]       out_active_terminal,
  output logic [10:0]      out_pending_input
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int TOTAL = TERMINALS * CELLS;
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int EW    = $clog2(CELLS);
  localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int AW    = $clog2(TOTAL);

  localparam logic [CW-1:0] COL_END  = CW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [NW-1:0] N_CELLS  = NW'(CELLS);
  localparam logic [NW-1:0] N_CLIP   = NW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] A_LAST   = AW'(TOTAL - 1);
  localparam logic [AW-1:0] SC_MOVE  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] SC_END   = AW'(CELLS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [TW-1:0] t,
                                              input logic [NW-1:0] off);
    cell_addr = AW'(32'(t) * CELLS + 32'(off));
  endfunction

  state_t        state_r, state_nxt, ret_r, ret_nxt;
  logic [TW-1:0] act_r, act_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [AW-1:0] sc_r, sc_nxt;
  logic [NW-1:0] idx_r, idx_nxt, n_r, n_nxt, head_r, head_nxt;
  logic [15:0]   cell_r, cell_nxt;

  logic [RW-1:0] row_r   [TERMINALS];
  logic [RW-1:0] row_nxt [TERMINALS];
  logic [CW-1:0] col_r   [TERMINALS];
  logic [CW-1:0] col_nxt [TERMINALS];
  logic [NW-1:0] cnt_r   [TERMINALS];
  logic [NW-1:0] cnt_nxt [TERMINALS];
  logic [7:0]    clr_r   [TERMINALS];
  logic [7:0]    clr_nxt [TERMINALS];

  logic          out_valid_r;
  logic [6:0]    out_col_r;
  logic [4:0]    out_row_r;
  logic [15:0]   out_cell_r;
  logic [1:0]    out_term_r;
  logic [10:0]   out_pend_r;
  logic          load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [7:0]    e_wdata, e_rdata;

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [NW-1:0] cur_cnt;
  logic [7:0]    cur_clr;
  logic [NW-1:0] pos;
  logic [NW-1:0] fl_n, fl_head0, fl_head;
  logic [RW-1:0] bs_row;
  logic [CW-1:0] bs_col;
  logic          accept;

  tcw_ram #(.DEPTH(TOTAL), .WIDTH(16)) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_ram #(.DEPTH(CELLS), .WIDTH(8)) u_echo (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  assign cur_row  = row_r[act_r];
  assign cur_col  = col_r[act_r];
  assign cur_cnt  = cnt_r[act_r];
  assign cur_clr  = clr_r[act_r];
  assign pos      = NW'(32'(cur_row) * COLUMNS + 32'(cur_col));
  assign fl_n     = (cur_cnt > N_CELLS) ? N_CELLS : cur_cnt;
  assign fl_head0 = (pos >= fl_n) ? pos - fl_n : '0;
  assign fl_head  = (({1'b0, fl_head0} + {1'b0, fl_n}) > {1'b0, N_CELLS}) ?
                    N_CELLS - fl_n : fl_head0;
  assign bs_row   = (cur_col == '0) ? cur_row - RW'(1) : cur_row;
  assign bs_col   = (cur_col == '0) ? COL_LAST : cur_col - CW'(1);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    act_nxt   = act_r;
    ch_nxt    = ch_r;
    sc_nxt    = sc_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    head_nxt  = head_r;
    cell_nxt  = cell_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    load      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cell_addr(act_r, pos);
    mem_wdata = {cur_clr, ch_r};
    mem_raddr = cell_addr(act_r, pos);
    e_we      = 1'b0;
    e_waddr   = idx_r[EW-1:0];
    e_wdata   = mem_rdata[7:0];
    e_raddr   = idx_r[EW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sc_r;
        mem_wdata = RESET_CELL;
        if (sc_r == A_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_nxt  = '0;
          ch_nxt    = in_char_code;
          state_nxt = ST_DONE;
          unique case (req_t'(in_req_type))
            REQ_PUT: begin
              ret_nxt   = ST_DONE;
              state_nxt = ST_PUT;
            end
            REQ_INPUT: begin
              ret_nxt   = ST_INC;
              state_nxt = ST_PUT;
            end
            REQ_BS: begin
              if (cur_cnt != '0) begin
                cnt_nxt[act_r] = cur_cnt - NW'(1);
                if (!(cur_col == '0 && cur_row == '0)) begin
                  row_nxt[act_r] = bs_row;
                  col_nxt[act_r] = bs_col;
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(act_r,
                                NW'(32'(bs_row) * COLUMNS + 32'(bs_col)));
                  mem_wdata = {cur_clr, BLANK_CODE};
                end
              end
            end
            REQ_FLUSH: begin
              idx_nxt  = '0;
              n_nxt    = fl_n;
              head_nxt = fl_head;
              if (fl_n == '0) begin
                ch_nxt    = NEWLINE_CODE;
                ret_nxt   = ST_DONE;
                state_nxt = ST_PUT;
              end else begin
                state_nxt = ST_FL_RD;
              end
            end
            REQ_SWITCH: begin
              if (32'(in_terminal_index) < TERMINALS) begin
                act_nxt = TW'(in_terminal_index);
              end
            end
            REQ_COLOR: begin
              clr_nxt[act_r] = in_color_value;
            end
            REQ_READ: begin
              if (32'(in_cell_index) < CELLS) begin
                mem_raddr = cell_addr(act_r, NW'(in_cell_index));
                state_nxt = ST_RD_DATA;
              end
            end
            REQ_NONE: begin
            end
          endcase
        end
      end
      ST_PUT: begin
        state_nxt = ST_PUT_WR;
        if (ch_r == NEWLINE_CODE || cur_col >= COL_END) begin
          col_nxt[act_r] = '0;
          if (cur_row == ROW_LAST) begin
            if (cur_cnt > N_CLIP) begin
              cnt_nxt[act_r] = N_CLIP;
            end
            sc_nxt    = '0;
            state_nxt = ST_SC_RD;
          end else begin
            row_nxt[act_r] = cur_row + RW'(1);
          end
        end
      end
      ST_PUT_WR: begin
        if (ch_r != NEWLINE_CODE) begin
          mem_we         = 1'b1;
          col_nxt[act_r] = cur_col + CW'(1);
        end
        state_nxt = ret_r;
      end
      ST_SC_RD: begin
        mem_raddr = cell_addr(act_r, NW'(sc_r) + NW'(COLUMNS));
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(act_r, NW'(sc_r));
        mem_wdata = mem_rdata;
        sc_nxt    = sc_r + AW'(1);
        state_nxt = (sc_r == SC_MOVE) ? ST_SC_BLANK : ST_SC_RD;
      end
      ST_SC_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(act_r, NW'(sc_r));
        mem_wdata = {cur_clr, BLANK_CODE};
        if (sc_r == SC_END) begin
          row_nxt[act_r] = ROW_LAST;
          state_nxt      = ST_PUT_WR;
        end else begin
          sc_nxt = sc_r + AW'(1);
        end
      end
      ST_INC: begin
        if (cur_cnt < N_CELLS) begin
          cnt_nxt[act_r] = cur_cnt + NW'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_FL_RD: begin
        mem_raddr = cell_addr(act_r, head_r + idx_r);
        state_nxt = ST_FL_WR;
      end
      ST_FL_WR: begin
        e_we = 1'b1;
        if (idx_r + NW'(1) == n_r) begin
          idx_nxt   = '0;
          ch_nxt    = NEWLINE_CODE;
          ret_nxt   = ST_FL_ERD;
          state_nxt = ST_PUT;
        end else begin
          idx_nxt   = idx_r + NW'(1);
          state_nxt = ST_FL_RD;
        end
      end
      ST_FL_ERD: begin
        state_nxt = ST_FL_ELD;
      end
      ST_FL_ELD: begin
        ch_nxt    = e_rdata;
        ret_nxt   = (idx_r + NW'(1) == n_r) ? ST_FL_NL2 : ST_FL_ERD;
        idx_nxt   = idx_r + NW'(1);
        state_nxt = ST_PUT;
      end
      ST_FL_NL2: begin
        ch_nxt    = NEWLINE_CODE;
        ret_nxt   = ST_FL_CLR;
        state_nxt = ST_PUT;
      end
      ST_FL_CLR: begin
        cnt_nxt[act_r] = '0;
        state_nxt      = ST_DONE;
      end
      ST_RD_DATA: begin
        cell_nxt  = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_DONE;
      act_r       <= '0;
      sc_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        row_r[i] <= '0;
        col_r[i] <= '0;
        cnt_r[i] <= '0;
        clr_r[i] <= RESET_COLOR;
      end
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      act_r   <= act_nxt;
      sc_r    <= sc_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    head_r <= head_nxt;
    cell_r <= cell_nxt;
    if (load) begin
      out_col_r  <= 7'(cur_col);
      out_row_r  <= 5'(cur_row);
      out_cell_r <= cell_r;
      out_term_r <= 2'(act_r);
      out_pend_r <= 11'(cur_cnt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_col      = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_cell_value      = out_cell_r;
  assign out_active_terminal = out_term_r;
  assign out_pending_input   = out_pend_r;

endmodule
`default_nettype wire

>>> sv/tcw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int TERMINALS = 4,
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_req_type,
  input wire logic [7:0]  in_char_code,
  input wire logic [7:0]  in_color_value,
  input wire logic [1:0]  in_terminal_index,
  input wire logic [10:0] in_cell_index,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  out_cursor_col,
  input wire logic [4:0]  out_cursor_row,
  input wire logic [15:0] out_cell_value,
  input wire logic [1:0]  out_active_terminal,
  input wire logic [10:0] out_pending_input
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value))
    else $error("result item dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_row) < ROWS) && (32'(out_cursor_col) <= COLUMNS))
    else $error("cursor outside the screen");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_pending_input) <= ROWS * COLUMNS) &&
                  (32'(out_active_terminal) < TERMINALS))
    else $error("pending count or terminal out of range");

endmodule

bind text_console_writer tcw_checker #(
  .TERMINALS (TERMINALS),
  .COLUMNS   (COLUMNS),
  .ROWS      (ROWS)
) u_tcw_checker (.*);
`default_nettype wire
